@@ src/apfp_pkg.sv @@
// Shared types, constants and helpers for the audio packet FIFO pacer.
`timescale 1ns / 1ps

package apfp_pkg;

    localparam int RING_SLOTS       = 256;
    localparam int WORDS_PER_PACKET = 36;
    localparam int STORE_DEPTH      = RING_SLOTS * WORDS_PER_PACKET;
    localparam int SLOT_W           = $clog2(RING_SLOTS);
    localparam int WIDX_W           = (WORDS_PER_PACKET > 1) ? $clog2(WORDS_PER_PACKET) : 1;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);
    localparam int WORD_W           = 32;
    localparam int LEVEL_W          = 8;

    localparam logic [31:0] PULL_QUANTUM   = 32'h0004_0000;
    localparam logic [31:0] RATE_RESET     = 32'd99864;
    localparam logic [31:0] ACC_SATURATED  = 32'hFFFF_FFFF;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [WIDX_W-1:0]  widx_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [LEVEL_W-1:0] level_t;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_TICK = 2'd1,
        OP_PULL = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DROP    = 3'd1,
        ST_NOT_DUE = 3'd2,
        ST_WORD    = 3'd3,
        ST_SILENCE = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_STREAM = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic take;   // input item accepted, execute it
        logic load;   // move the current stored word into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pull_stream;  // pending item is a due pull with a packet waiting
        logic word_final;   // stream counter sits on the packet's last word
        logic out_free;     // output register can take a result this cycle
    } stat_t;

    function automatic slot_t next_slot(input slot_t s);
        slot_t r;
        if (s == slot_t'(RING_SLOTS - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    function automatic level_t fill_level(input slot_t head, input slot_t tail);
        logic [SLOT_W:0] lv;
        if (head >= tail) begin
            lv = {1'b0, head} - {1'b0, tail};
        end else begin
            lv = (SLOT_W + 1)'(RING_SLOTS) + {1'b0, head} - {1'b0, tail};
        end
        if (lv > (SLOT_W + 1)'(255)) begin
            return level_t'(255);
        end
        return level_t'(lv);
    endfunction

endpackage

@@ src/apfp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module apfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/apfp_ctrl.sv @@
// Controller: accepts items and sequences packet streaming.
`timescale 1ns / 1ps

module apfp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  apfp_pkg::stat_t stat,
    output apfp_pkg::cmd_t  cmd
);

    apfp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= apfp_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            apfp_pkg::S_IDLE: begin
                s_tready = stat.out_free;
                cmd.take = s_tvalid && stat.out_free;
                if (cmd.take && stat.pull_stream) begin
                    state_next = apfp_pkg::S_STREAM;
                end
            end
            apfp_pkg::S_STREAM: begin
                cmd.load = stat.out_free;
                if (cmd.load && stat.word_final) begin
                    state_next = apfp_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = apfp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ src/apfp_dp.sv @@
// Datapath: ring pointers, pacer accumulator, packet store and output register.
`timescale 1ns / 1ps

module apfp_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             s_tuser,
    input  logic [31:0]            s_tdata,
    input  logic                   s_tlast,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [2:0]             m_tuser,
    output logic [39:0]            m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic [31:0]            cfg_wr_data,
    input  apfp_pkg::cmd_t         cmd,
    output apfp_pkg::stat_t        stat
);

    apfp_pkg::slot_t  head_reg, head_next;
    apfp_pkg::slot_t  tail_reg, tail_next;
    logic [31:0]      acc_reg, acc_next;
    logic [31:0]      rate_reg;
    apfp_pkg::widx_t  pos_reg, pos_next;
    logic             dropping_reg, dropping_next;
    apfp_pkg::widx_t  rd_cnt_reg, rd_cnt_next;
    apfp_pkg::addr_t  rd_addr_reg, rd_addr_next;

    logic             m_valid_reg;
    apfp_pkg::status_t status_reg;
    apfp_pkg::word_t  word_reg;
    logic             last_reg;
    apfp_pkg::level_t level_reg;

    apfp_pkg::addr_t  head_base, tail_base;
    logic             ram_we, ram_re;
    apfp_pkg::addr_t  ram_waddr, ram_raddr;
    apfp_pkg::word_t  ram_rdata;

    logic             ld;
    apfp_pkg::status_t ld_status;
    apfp_pkg::word_t  ld_word;
    logic             ld_last;
    logic [32:0]      acc_sum;
    logic             pos_at_end;

    assign head_base  = apfp_pkg::addr_t'(head_reg) *
                        apfp_pkg::addr_t'(apfp_pkg::WORDS_PER_PACKET);
    assign tail_base  = apfp_pkg::addr_t'(tail_reg) *
                        apfp_pkg::addr_t'(apfp_pkg::WORDS_PER_PACKET);
    assign acc_sum    = {1'b0, acc_reg} + {1'b0, rate_reg};
    assign pos_at_end = (pos_reg == apfp_pkg::widx_t'(apfp_pkg::WORDS_PER_PACKET - 1));

    assign stat.out_free    = !m_valid_reg || m_tready;
    assign stat.word_final  = (rd_cnt_reg == apfp_pkg::widx_t'(apfp_pkg::WORDS_PER_PACKET - 1));
    assign stat.pull_stream = (s_tuser == apfp_pkg::OP_PULL) && (acc_reg >= apfp_pkg::PULL_QUANTUM)
                              && (tail_reg != head_reg);

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        acc_next      = acc_reg;
        pos_next      = pos_reg;
        dropping_next = dropping_reg;
        rd_cnt_next   = rd_cnt_reg;
        rd_addr_next  = rd_addr_reg;
        ram_we        = 1'b0;
        ram_waddr     = head_base + apfp_pkg::addr_t'(pos_reg);
        ram_re        = 1'b0;
        ram_raddr     = tail_base;
        ld            = 1'b0;
        ld_status     = apfp_pkg::ST_OK;
        ld_word       = '0;
        ld_last       = 1'b1;

        if (cmd.take) begin
            ld = 1'b1;
            case (s_tuser)
                apfp_pkg::OP_PUSH: begin
                    if (!s_tlast) begin
                        if (dropping_reg || pos_at_end) begin
                            dropping_next = 1'b1;
                        end else begin
                            ram_we   = 1'b1;
                            pos_next = pos_reg + 1'b1;
                        end
                    end else begin
                        pos_next      = '0;
                        dropping_next = 1'b0;
                        if (!dropping_reg && pos_at_end &&
                            apfp_pkg::next_slot(head_reg) != tail_reg) begin
                            ram_we    = 1'b1;
                            head_next = apfp_pkg::next_slot(head_reg);
                        end else begin
                            ld_status = apfp_pkg::ST_DROP;
                        end
                    end
                end
                apfp_pkg::OP_TICK: begin
                    acc_next = acc_sum[32] ? apfp_pkg::ACC_SATURATED : acc_sum[31:0];
                end
                apfp_pkg::OP_PULL: begin
                    if (acc_reg < apfp_pkg::PULL_QUANTUM) begin
                        ld_status = apfp_pkg::ST_NOT_DUE;
                    end else begin
                        acc_next = acc_reg - apfp_pkg::PULL_QUANTUM;
                        if (tail_reg != head_reg) begin
                            // first word read now, streamed out from the stream state
                            ld           = 1'b0;
                            tail_next    = apfp_pkg::next_slot(tail_reg);
                            ram_re       = 1'b1;
                            ram_raddr    = tail_base;
                            rd_addr_next = tail_base;
                            rd_cnt_next  = '0;
                        end else begin
                            ld_status = apfp_pkg::ST_SILENCE;
                        end
                    end
                end
                default: begin
                    ld_status = apfp_pkg::ST_OK;
                end
            endcase
        end else if (cmd.load) begin
            ld        = 1'b1;
            ld_status = apfp_pkg::ST_WORD;
            ld_word   = ram_rdata;
            ld_last   = stat.word_final;
            if (!stat.word_final) begin
                rd_cnt_next  = rd_cnt_reg + 1'b1;
                rd_addr_next = rd_addr_reg + 1'b1;
                ram_re       = 1'b1;
                ram_raddr    = rd_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            acc_reg      <= '0;
            rate_reg     <= apfp_pkg::RATE_RESET;
            pos_reg      <= '0;
            dropping_reg <= 1'b0;
            rd_cnt_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            acc_reg      <= acc_next;
            pos_reg      <= pos_next;
            dropping_reg <= dropping_next;
            rd_cnt_reg   <= rd_cnt_next;
            if (cfg_wr_en) begin
                rate_reg <= cfg_wr_data;
            end
            if (ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        if (ld) begin
            status_reg <= ld_status;
            word_reg   <= ld_word;
            last_reg   <= ld_last;
            level_reg  <= apfp_pkg::fill_level(head_next, tail_next);
        end
    end

    apfp_ram #(
        .WIDTH (apfp_pkg::WORD_W),
        .DEPTH (apfp_pkg::STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_tdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {level_reg, word_reg};
    assign m_tlast  = last_reg;

    // a packet being discarded has always run into its final position
    a_drop_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        dropping_reg |-> pos_at_end)
        else $error("drop flag set before the final word position");

    // the store is never written while a packet is being streamed out
    a_no_write_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !ram_we)
        else $error("store write during packet stream");

    a_stream_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load && stat.word_final |=> m_tvalid && m_tlast && m_tuser == apfp_pkg::ST_WORD)
        else $error("final streamed word not marked last");

    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take && !stat.pull_stream |=> m_tvalid && m_tlast && m_tdata[31:0] == '0)
        else $error("single-result item not presented as one last result");

    a_not_due_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take && s_tuser == apfp_pkg::OP_PULL && acc_reg < apfp_pkg::PULL_QUANTUM
        |=> $stable(acc_reg) && m_tuser == apfp_pkg::ST_NOT_DUE)
        else $error("pull that is not due changed the accumulator");

endmodule

@@ src/audio_packet_fifo_pacer_unit.sv @@
// Top level of the audio packet FIFO with fractional-rate pull pacer.
//
//  channel   ports                         item contents (low bit first)
//  input     s_tvalid/s_tready             tuser: operation, tdata: packet_word,
//                                          tlast: word_last
//  result    m_tvalid/m_tready             tuser: status, tdata: out_word, fill_level,
//                                          tlast: out_last
//  config    cfg_wr_en/cfg_wr_data         samples_per_line, written on the enable
//
// Pushes, ticks, pulls that are not due and silence pulls each give a single result.
// A due pull with a packet waiting first reads the packet's first word, then streams
// one word per cycle from the store's single read port while the output is not stalled.
// Reset clears pointers, accumulator and push state; the store needs no clearing.
// A stalled result holds in the output register and input waits until it leaves.
`timescale 1ns / 1ps

module audio_packet_fifo_pacer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] packet_word
    input  logic [1:0]  s_tuser,   // [1:0] operation
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] out_word, [39:32] fill_level
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    apfp_pkg::cmd_t  cmd;
    apfp_pkg::stat_t stat;

    apfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    apfp_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
